/* sv/sxlcd_pkg.sv */
// shared types, constants and helpers for the sysex lcd name parser
`default_nettype none

package sxlcd_pkg;

   localparam int NAME_DEPTH_DEFAULT = 64;
   localparam logic [6:0] LCD_COMMAND_RESET = 7'd18;
   localparam logic [7:0] END_OF_EXCLUSIVE = 8'hF7;
   localparam logic [9:0] DIV7_RECIPROCAL = 10'd293;
   localparam int DIV7_SHIFT = 11;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HEAD1     = 3'd1,
      PH_HEAD2     = 3'd2,
      PH_LCD_FIRST = 3'd3,
      PH_LCD_MID   = 3'd4,
      PH_LCD_LAST  = 3'd5,
      PH_SKIP      = 3'd6
   } phase_type;

   typedef struct packed {
      logic       is_system;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
   } req_word_type;

   typedef struct packed {
      logic        handled;
      logic [2:0]  fsm_state;
      logic [5:0]  track_number;
      logic [23:0] manufacturer_id;
      logic [7:0]  device_id;
      logic        name_clear;
      logic [1:0]  char_count;
      logic [5:0]  char_index;
      logic [7:0]  char_a;
      logic [7:0]  char_b;
      logic [7:0]  char_c;
      logic        name_overflow;
   } rsp_word_type;

   // track number from lcd offset: offset / 7 + 1, exact for 8-bit offsets
   function automatic logic [5:0] track_from_offset(input logic [7:0] offset);
      logic [17:0] product;
      logic [5:0]  quotient;
      product  = {10'd0, offset} * {8'd0, DIV7_RECIPROCAL};
      quotient = product[DIV7_SHIFT +: 6];
      return quotient + 6'd1;
   endfunction

endpackage

`default_nettype wire

/* sv/control_sysex_lcd_name_parser.sv */
// top level of the sysex lcd name parser
//
// usage:
//   req channel (req_valid/req_ready/req_word) carries one three-byte midi
//   packet per word with its system-exclusive flag.
//   rsp channel (rsp_valid/rsp_ready/rsp_word) returns exactly one word per
//   accepted packet: phase, header ids, track number and up to three name
//   characters with their index, plus clear and overflow flags. the name
//   buffer itself sits in the receiver.
//   csr_write_enable/csr_write_data set the lcd command code (reset 18);
//   write it only while no packet is in flight.
// result: registered, valid in the cycle after the packet is accepted.
// throughput: one packet per cycle unless stalled; state update and result are
//   a short path of logic between the phase registers and the result register.
// reset: synchronous, active high; phase goes idle, ids, track and name
//   position clear, the command code returns to 18 and no result is pending.
// stall: while rsp_ready is low a pending result holds and req_ready drops;
//   a new packet is taken in the same cycle the pending result is taken.
`default_nettype none

module control_sysex_lcd_name_parser #(
   parameter int NAME_DEPTH = sxlcd_pkg::NAME_DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire sxlcd_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output sxlcd_pkg::rsp_word_type rsp_word,
   input  wire                     csr_write_enable,
   input  wire  [6:0]              csr_write_data
);

   localparam int PW = $clog2(NAME_DEPTH + 1);
   localparam logic [PW-1:0] DEPTH = PW'(NAME_DEPTH);

   sxlcd_pkg::phase_type phase_ff, phase_in;
   logic [23:0]   maker_ff, maker_in;
   logic [7:0]    device_ff, device_in;
   logic          is_lcd_ff, is_lcd_in;
   logic [5:0]    track_ff, track_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [6:0]    code_ff;
   logic          rsp_valid_ff;
   sxlcd_pkg::rsp_word_type rsp_ff, rsp_in;

   logic          accept;
   logic          writes;
   logic [1:0]    wanted;
   logic [1:0]    taken;
   logic [PW-1:0] base;
   logic [PW-1:0] room;
   logic [7:0]    ch0, ch1, ch2;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      phase_in  = phase_ff;
      maker_in  = maker_ff;
      device_in = device_ff;
      is_lcd_in = is_lcd_ff;
      track_in  = track_ff;
      pos_in    = pos_ff;
      rsp_in    = '0;
      writes    = 1'b0;
      wanted    = 2'd0;
      base      = pos_ff;
      ch0       = req_word.byte_one;
      ch1       = req_word.byte_two;
      ch2       = req_word.byte_three;

      case (phase_ff)
         sxlcd_pkg::PH_HEAD1: phase_in = sxlcd_pkg::PH_HEAD2;
         sxlcd_pkg::PH_HEAD2: phase_in = is_lcd_ff ? sxlcd_pkg::PH_LCD_FIRST
                                                   : sxlcd_pkg::PH_SKIP;
         sxlcd_pkg::PH_LCD_FIRST: phase_in = sxlcd_pkg::PH_LCD_MID;
         sxlcd_pkg::PH_LCD_MID: begin
            if (req_word.byte_three == sxlcd_pkg::END_OF_EXCLUSIVE) begin
               phase_in = sxlcd_pkg::PH_LCD_LAST;
            end
         end
         sxlcd_pkg::PH_LCD_LAST: phase_in = sxlcd_pkg::PH_IDLE;
         sxlcd_pkg::PH_SKIP: begin
            if (req_word.byte_three == sxlcd_pkg::END_OF_EXCLUSIVE) begin
               phase_in = sxlcd_pkg::PH_IDLE;
            end
         end
         default: phase_in = req_word.is_system ? sxlcd_pkg::PH_HEAD1
                                                : sxlcd_pkg::PH_IDLE;
      endcase

      case (phase_in)
         sxlcd_pkg::PH_IDLE: begin
            maker_in          = '0;
            device_in         = '0;
            track_in          = '0;
            pos_in            = '0;
            rsp_in.name_clear = 1'b1;
         end
         sxlcd_pkg::PH_HEAD1: begin
            maker_in = {req_word.byte_two, req_word.byte_three, 8'd0};
         end
         sxlcd_pkg::PH_HEAD2: begin
            maker_in  = maker_ff + {16'd0, req_word.byte_one};
            device_in = req_word.byte_two;
            is_lcd_in = req_word.byte_three == {1'b0, code_ff};
         end
         sxlcd_pkg::PH_LCD_FIRST: begin
            track_in          = sxlcd_pkg::track_from_offset(req_word.byte_one);
            rsp_in.name_clear = 1'b1;
            writes            = 1'b1;
            wanted            = 2'd2;
            base              = '0;
            ch0               = req_word.byte_two;
            ch1               = req_word.byte_three;
         end
         sxlcd_pkg::PH_LCD_MID: begin
            writes = 1'b1;
            wanted = 2'd3;
         end
         sxlcd_pkg::PH_LCD_LAST: begin
            writes = 1'b1;
            wanted = 2'd2;
         end
         default: begin
         end
      endcase

      room  = (base < DEPTH) ? DEPTH - base : '0;
      taken = ({{(PW-2){1'b0}}, wanted} < room) ? wanted : room[1:0];
      if (writes) begin
         pos_in               = base + {{(PW-2){1'b0}}, taken};
         rsp_in.char_count    = taken;
         rsp_in.char_a        = (taken > 2'd0) ? ch0 : 8'd0;
         rsp_in.char_b        = (taken > 2'd1) ? ch1 : 8'd0;
         rsp_in.char_c        = (taken > 2'd2) ? ch2 : 8'd0;
         rsp_in.name_overflow = taken < wanted;
      end
      rsp_in.char_index = (phase_in == sxlcd_pkg::PH_IDLE) ? 6'd0 : 6'(base);

      rsp_in.handled = !(phase_ff == sxlcd_pkg::PH_IDLE &&
                         phase_in == sxlcd_pkg::PH_IDLE);
      rsp_in.fsm_state       = phase_in;
      rsp_in.track_number    = track_in;
      rsp_in.manufacturer_id = maker_in;
      rsp_in.device_id       = device_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sxlcd_pkg::PH_IDLE;
         maker_ff     <= '0;
         device_ff    <= '0;
         is_lcd_ff    <= 1'b0;
         track_ff     <= '0;
         pos_ff       <= '0;
         code_ff      <= sxlcd_pkg::LCD_COMMAND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            code_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            maker_ff  <= maker_in;
            device_ff <= device_in;
            is_lcd_ff <= is_lcd_in;
            track_ff  <= track_in;
            pos_ff    <= pos_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* tb/control_sysex_lcd_name_parser_tb.sv */
// testbench for the sysex lcd name parser: predicted result words checked against the rsp channel
`default_nettype none

module control_sysex_lcd_name_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NAME_LENGTH = sxlcd_pkg::NAME_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 370;

   class lcd_name_scoreboard;
      sxlcd_pkg::phase_type    phase;
      logic [23:0]             maker;
      logic [7:0]              device;
      logic                    lcd_selected;
      logic [5:0]              track;
      int unsigned             name_pos;
      logic [6:0]              command_code;
      sxlcd_pkg::rsp_word_type expected_words[$];
      int                      mismatches;

      function new();
         phase = sxlcd_pkg::PH_IDLE;
         maker = '0;
         device = '0;
         lcd_selected = 1'b0;
         track = '0;
         name_pos = 0;
         command_code = sxlcd_pkg::LCD_COMMAND_RESET;
         mismatches = 0;
      endfunction

      function void put_name_chars(inout sxlcd_pkg::rsp_word_type r,
                                   input logic [7:0] c0, c1, c2, input int n);
         int room;
         int k;
         room = (name_pos < NAME_LENGTH) ? NAME_LENGTH - name_pos : 0;
         k = (n < room) ? n : room;
         r.char_count = k[1:0];
         r.char_index = name_pos[5:0];
         if (k > 0) r.char_a = c0;
         if (k > 1) r.char_b = c1;
         if (k > 2) r.char_c = c2;
         r.name_overflow = (k < n);
         name_pos += k;
      endfunction

      function void note_packet(sxlcd_pkg::req_word_type w);
         sxlcd_pkg::rsp_word_type r;
         sxlcd_pkg::phase_type    prior;
         int                      t;
         r = '0;
         prior = phase;
         case (phase)
            sxlcd_pkg::PH_HEAD1: phase = sxlcd_pkg::PH_HEAD2;
            sxlcd_pkg::PH_HEAD2:
               phase = lcd_selected ? sxlcd_pkg::PH_LCD_FIRST : sxlcd_pkg::PH_SKIP;
            sxlcd_pkg::PH_LCD_FIRST: phase = sxlcd_pkg::PH_LCD_MID;
            sxlcd_pkg::PH_LCD_MID:
               if (w.byte_three == sxlcd_pkg::END_OF_EXCLUSIVE)
                  phase = sxlcd_pkg::PH_LCD_LAST;
            sxlcd_pkg::PH_LCD_LAST: phase = sxlcd_pkg::PH_IDLE;
            sxlcd_pkg::PH_SKIP:
               if (w.byte_three == sxlcd_pkg::END_OF_EXCLUSIVE) phase = sxlcd_pkg::PH_IDLE;
            default: phase = w.is_system ? sxlcd_pkg::PH_HEAD1 : sxlcd_pkg::PH_IDLE;
         endcase
         case (phase)
            sxlcd_pkg::PH_IDLE: begin
               maker = '0;
               device = '0;
               track = '0;
               name_pos = 0;
               r.name_clear = 1'b1;
            end
            sxlcd_pkg::PH_HEAD1: begin
               maker = {w.byte_two, w.byte_three, 8'h00};
               r.char_index = name_pos[5:0];
            end
            sxlcd_pkg::PH_HEAD2: begin
               maker = maker + {16'd0, w.byte_one};
               device = w.byte_two;
               lcd_selected = (w.byte_three == {1'b0, command_code});
               r.char_index = name_pos[5:0];
            end
            sxlcd_pkg::PH_LCD_FIRST: begin
               t = int'(w.byte_one);
               t = t / 7 + 1;
               track = t[5:0];
               name_pos = 0;
               r.name_clear = 1'b1;
               put_name_chars(r, w.byte_two, w.byte_three, 8'h00, 2);
            end
            sxlcd_pkg::PH_LCD_MID:
               put_name_chars(r, w.byte_one, w.byte_two, w.byte_three, 3);
            sxlcd_pkg::PH_LCD_LAST: put_name_chars(r, w.byte_one, w.byte_two, 8'h00, 2);
            default: r.char_index = name_pos[5:0];
         endcase
         r.handled = !(prior == sxlcd_pkg::PH_IDLE && phase == sxlcd_pkg::PH_IDLE);
         r.fsm_state = phase;
         r.track_number = track;
         r.manufacturer_id = maker;
         r.device_id = device;
         expected_words.push_back(r);
      endfunction

      function void check_field(string field, logic [23:0] want, logic [23:0] seen);
         if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch in %s: expected %0h, got %0h", field, want, seen);
         end
      endfunction

      function void check_result(sxlcd_pkg::rsp_word_type got);
         sxlcd_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = expected_words.pop_front();
         check_field("handled", 24'(want.handled), 24'(got.handled));
         check_field("fsm_state", 24'(want.fsm_state), 24'(got.fsm_state));
         check_field("track_number", 24'(want.track_number), 24'(got.track_number));
         check_field("manufacturer_id", want.manufacturer_id, got.manufacturer_id);
         check_field("device_id", 24'(want.device_id), 24'(got.device_id));
         check_field("name_clear", 24'(want.name_clear), 24'(got.name_clear));
         check_field("char_count", 24'(want.char_count), 24'(got.char_count));
         check_field("char_index", 24'(want.char_index), 24'(got.char_index));
         check_field("char_a", 24'(want.char_a), 24'(got.char_a));
         check_field("char_b", 24'(want.char_b), 24'(got.char_b));
         check_field("char_c", 24'(want.char_c), 24'(got.char_c));
         check_field("name_overflow", 24'(want.name_overflow), 24'(got.name_overflow));
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sxlcd_pkg::req_word_type req_word = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b1;
   sxlcd_pkg::rsp_word_type rsp_word;
   logic                    csr_write_enable = 1'b0;
   logic [6:0]              csr_write_data = '0;

   lcd_name_scoreboard sb;
   int  cycle_count = 0;
   int  packets_sent = 0;
   int  burst_left = 0;
   int  rush_left = 0;
   bit  hold_request = 1'b0;

   control_sysex_lcd_name_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("control_sysex_lcd_name_parser_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_word);
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int run;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic sxlcd_pkg::req_word_type make_word(logic s, logic [7:0] b1, b2, b3);
      sxlcd_pkg::req_word_type w;
      w.is_system = s;
      w.byte_one = b1;
      w.byte_two = b2;
      w.byte_three = b3;
      return w;
   endfunction

   function automatic sxlcd_pkg::req_word_type any_word();
      logic [31:0] r;
      r = $urandom;
      return r[24:0];
   endfunction

   function automatic sxlcd_pkg::req_word_type open_word();
      sxlcd_pkg::req_word_type w;
      w = any_word();
      if (w.byte_three == sxlcd_pkg::END_OF_EXCLUSIVE) w.byte_three = 8'hF6;
      return w;
   endfunction

   task automatic offer_packet(input sxlcd_pkg::req_word_type w, input bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (rush_left > 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (rush_left > 0) rush_left--;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_packet(w);
      if (counted) packets_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_command_code(input logic [6:0] code);
      csr_write_enable <= 1'b1;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.command_code = code;
      @(posedge clock);
   endtask

   task automatic send_message();
      int kind;
      int body;
      sxlcd_pkg::req_word_type w;
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
         w = any_word();
         w.is_system = 1'b1;
         offer_packet(w, 1'b1);
         w = any_word();
         if (kind <= 5) begin
            w.byte_three = {1'b0, sb.command_code};
         end else if (w.byte_three == {1'b0, sb.command_code}) begin
            w.byte_three[7] = 1'b1;
         end
         offer_packet(w, 1'b1);
         if (kind <= 5) begin
            // lcd first, then the forced middle word
            offer_packet(any_word(), 1'b1);
            offer_packet(any_word(), 1'b1);
            body = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 26) : $urandom_range(0, 6);
         end else begin
            body = $urandom_range(0, 5);
         end
         repeat (body) offer_packet(open_word(), 1'b1);
         w = any_word();
         w.byte_three = sxlcd_pkg::END_OF_EXCLUSIVE;
         offer_packet(w, 1'b1);
         if (kind <= 5) offer_packet(any_word(), 1'b1);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 3)) begin
            w = any_word();
            w.is_system = 1'b0;
            offer_packet(w, 1'b0);
         end
      end else begin
         repeat ($urandom_range(1, 8)) offer_packet(any_word(), 1'b1);
      end
   endtask

   initial begin
      sxlcd_pkg::req_word_type opening_words[$];
      logic [6:0]              code_plan[5];
      int                      start;
      sb = new();
      opening_words = '{
         make_word(1'b0, 8'h00, 8'h00, 8'h00), make_word(1'b0, 8'hFF, 8'hFF, 8'hFF),
         make_word(1'b1, 8'hFF, 8'hFF, 8'hFF), make_word(1'b0, 8'hFF, 8'hFF, 8'h12),
         make_word(1'b0, 8'hFF, 8'hF7, 8'hF7), make_word(1'b1, 8'h00, 8'h00, 8'hF7),
         make_word(1'b0, 8'h41, 8'h42, 8'hF7), make_word(1'b1, 8'hFF, 8'hFF, 8'hFF),
         make_word(1'b1, 8'h00, 8'h00, 8'h00), make_word(1'b1, 8'h00, 8'h00, 8'h00),
         make_word(1'b0, 8'hAA, 8'h55, 8'hF6), make_word(1'b1, 8'h55, 8'hAA, 8'hF7),
         make_word(1'b1, 8'h12, 8'h34, 8'h56), make_word(1'b0, 8'h78, 8'h9A, 8'h92),
         make_word(1'b0, 8'h00, 8'h00, 8'hF7),
         make_word(1'b1, 8'h7F, 8'h80, 8'h01), make_word(1'b0, 8'h01, 8'h02, 8'h12),
         make_word(1'b0, 8'h00, 8'h61, 8'h62), make_word(1'b0, 8'h63, 8'h64, 8'h65),
         make_word(1'b0, 8'h66, 8'h67, 8'hF7), make_word(1'b0, 8'h00, 8'h00, 8'h00)
      };
      code_plan[0] = 7'd127;
      code_plan[1] = 7'd0;
      code_plan[2] = 7'($urandom_range(1, 126));
      code_plan[3] = 7'($urandom_range(1, 126));
      code_plan[4] = sxlcd_pkg::LCD_COMMAND_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_words[i]) offer_packet(opening_words[i], 1'b1);
      drain();
      foreach (code_plan[i]) begin
         write_command_code(code_plan[i]);
         if (i == 1) begin
            hold_request = 1'b1;
            rush_left = 60;
         end
         start = packets_sent;
         while (packets_sent - start < PHASE_WORDS) send_message();
         drain();
      end
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0)
         $display("control_sysex_lcd_name_parser_tb passed");
      else
         $display("control_sysex_lcd_name_parser_tb failed");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/sxlcd_pkg.sv
sv/control_sysex_lcd_name_parser.sv
tb/control_sysex_lcd_name_parser_tb.sv
